// ----- hdl/dpof_pkg.sv -----
`timescale 1ns / 1ps
// dpof_pkg: widths, constants and shared types for the dust pulse occupancy filter
// used by dpof_div, dust_pulse_occupancy_filter_top and the testbench; no dependencies
package dpof_pkg;

    localparam int WIDTH_W = 20;
    localparam int TIME_W  = 32;
    localparam int WIN_W   = 16;
    localparam int SUM_W   = 40;
    localparam int CONC_W  = 29;
    localparam int RATIO_W = 23;
    localparam int R2_W    = 30;
    localparam int MUL_A_W = 37;
    localparam int MUL_B_W = 23;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 45;
    localparam int DSR_W   = 20;
    localparam int DVD_W   = 29;
    localparam int STEP_W  = 5;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [SUM_W-1:0]   SUM_MAX    = '1;
    localparam logic [CONC_W-1:0]  CONC_MAX   = '1;
    localparam logic [RATIO_W-1:0] RATIO_MAX  = RATIO_W'(100 * 65536);
    localparam logic               ENABLE_RST = 1'b1;
    localparam logic [WIN_W-1:0]   WINDOW_RST = WIN_W'(5000);

    // curve coefficients: K_CUBE, K_SQUARE and K_LINEAR in units of 1/100, K_OFFSET in units of 1/(100*65536)
    localparam logic [MUL_B_W-1:0] K_CUBE   = MUL_B_W'(110);
    localparam logic [MUL_B_W-1:0] K_SQUARE = MUL_B_W'(380);
    localparam logic [MUL_B_W-1:0] K_LINEAR = MUL_B_W'(52000);
    localparam logic signed [ACC_W-1:0] K_OFFSET = ACC_W'(62 * 65536);
    localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(12800);
    localparam logic [ACC_W-9:0]   CONC_LIM   = (ACC_W-8)'(100) << CONC_W;
    localparam logic [STEP_W-1:0]  STEPS_RATIO = STEP_W'(RATIO_W);

    // division by 100 and 10: coarse reciprocal estimate, then a fine pass on the remainder
    localparam logic [MUL_B_W-1:0] K_HUNDRED          = MUL_B_W'(100);
    localparam logic [MUL_B_W-1:0] K_TEN              = MUL_B_W'(10);
    localparam logic [MUL_B_W-1:0] RECIP_HUNDRED      = MUL_B_W'(5368709);   // 2^29 / 100 down
    localparam logic [MUL_B_W-1:0] RECIP_HUNDRED_FINE = MUL_B_W'(5243);      // 2^19 / 100 up
    localparam logic [MUL_B_W-1:0] RECIP_TEN          = MUL_B_W'(6710886);   // 2^26 / 10 down
    localparam logic [MUL_B_W-1:0] RECIP_TEN_FINE     = MUL_B_W'(205);       // 2^11 / 10 up

    // register index, taken from paddr[2]
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

endpackage

// ----- hdl/dust_pulse_occupancy_filter_top.sv -----
`timescale 1ns / 1ps
// dust_pulse_occupancy_filter_top: pulse accumulator, window sequencer, shared multiplier
// depends on dpof_pkg and dpof_div
//
//  channel  direction  ports                               content
//  s_       in         s_tvalid s_tready s_tdata[55:0]     low_pulse_us, now_ms
//  m_       out        m_tvalid m_tready m_tdata m_tuser   latest, filtered, window_done
//  apb      in/out     psel penable pwrite paddr pwdata    enable (0x0), sample_window_ms (0x4)
//
// an item that does not close a window passes through ST_ACC and ST_OUT before s_tready returns
// an item that closes a window first runs the serial ratio division in dpof_div (skipped when the
// ratio saturates), then up to eleven passes through the shared 37x23 multiplier for the curve and
// the divisions by 100 and 10 (the division by 100 is skipped when the concentration saturates)
// aresetn is synchronous; state, config, window sum and start, results and m_tvalid reset; datapath registers do not
// a held result on m_ does not block the next transfer on s_; only the following one

module dust_pulse_occupancy_filter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // low_pulse_us[19:0], now_ms[51:20], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // latest_concentration[28:0], filtered_dust[57:29], zero pad
    output logic        m_tuser,   // window_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [dpof_pkg::APB_AW-1:0] paddr,
    input  logic [dpof_pkg::APB_DW-1:0] pwdata,
    output logic [dpof_pkg::APB_DW-1:0] prdata,
    output logic        pready
);
    import dpof_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ACC, ST_RCHK, ST_RDIV, ST_SQ, ST_CUBE, ST_T3, ST_T2,
        ST_T1, ST_TSUM, ST_CDIV, ST_CEST, ST_CREM, ST_CFIX, ST_SMS, ST_SEST,
        ST_SREM, ST_SFIX, ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic                enable_reg, enable_next;
    logic [WIN_W-1:0]    window_reg, window_next;
    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [TIME_W-1:0]   start_reg, start_next;
    logic [CONC_W-1:0]   last_reg, last_next;
    logic [CONC_W-1:0]   smooth_reg, smooth_next;
    logic [RATIO_W-1:0]  ratio_reg, ratio_next;
    logic [R2_W-1:0]     r2_reg, r2_next;
    logic [CONC_W-1:0]   conc_reg, conc_next;
    logic [CONC_W-1:0]   est_reg, est_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                done_reg, done_next;
    logic                mvalid_reg, mvalid_next;
    logic [63:0]         mdata_reg, mdata_next;
    logic                muser_reg, muser_next;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    div_ctl_t            div_ctl;
    logic [DSR_W-1:0]    div_rem;
    logic [DVD_W-1:0]    div_dvd;
    logic [DSR_W-1:0]    div_dsr;
    logic                div_done;
    logic [DVD_W-1:0]    div_quo;

    logic                cfg_wr;
    logic [SUM_W:0]      sum_ext;
    logic [TIME_W-1:0]   elapsed;
    logic [DSR_W-1:0]    div10;
    logic [25:0]         lim;
    logic signed [ACC_W-1:0] prod_s;
    logic [ACC_W-1:0]    n_pos;
    logic [ACC_W-1:0]    n_rnd;
    logic [ACC_W-9:0]    m_val;
    logic [CONC_W+3:0]   x_val;
    logic [MUL_A_W-1:0]  c_rem;
    logic [MUL_A_W-1:0]  s_rem;

    dpof_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .rem_init (div_rem),
        .dvd_init (div_dvd),
        .dsr      (div_dsr),
        .done     (div_done),
        .quo      (div_quo)
    );

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_WINDOW) ? {{(APB_DW-WIN_W){1'b0}}, window_reg}
                                             : {{(APB_DW-1){1'b0}}, enable_reg};

    assign sum_ext = {1'b0, sum_reg} + {{(SUM_W-WIDTH_W+1){1'b0}}, width_reg};
    assign elapsed = now_reg - start_reg;
    assign div10   = ({{(DSR_W-WIN_W){1'b0}}, window_reg} << 3)
                   + ({{(DSR_W-WIN_W){1'b0}}, window_reg} << 1);
    assign lim     = 26'(window_reg) * 26'd1000;
    assign prod_s  = $signed({1'b0, prod_reg[ACC_W-2:0]});
    assign n_pos   = acc_reg[ACC_W-1] ? '0 : acc_reg;
    assign n_rnd   = n_pos + ROUND_HALF;
    assign m_val   = n_rnd[ACC_W-1:8];
    assign x_val   = ({4'b0, smooth_reg} << 3) + {4'b0, smooth_reg} + {4'b0, conc_reg}
                   + (CONC_W+4)'(5);
    assign c_rem   = m_val - prod_reg[MUL_A_W-1:0];
    assign s_rem   = {4'b0, x_val} - prod_reg[MUL_A_W-1:0];
    assign prod_next = mul_a * mul_b;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    always_comb begin
        state_next  = state_reg;
        enable_next = enable_reg;
        window_next = window_reg;
        width_next  = width_reg;
        now_next    = now_reg;
        sum_next    = sum_reg;
        start_next  = start_reg;
        last_next   = last_reg;
        smooth_next = smooth_reg;
        ratio_next  = ratio_reg;
        r2_next     = r2_reg;
        conc_next   = conc_reg;
        est_next    = est_reg;
        acc_next    = acc_reg;
        done_next   = done_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        mul_a       = {{(MUL_A_W-RATIO_W){1'b0}}, ratio_reg};
        mul_b       = ratio_reg;
        div_ctl     = '{start: 1'b0, steps: STEPS_RATIO};
        div_rem     = '0;
        div_dvd     = '0;
        div_dsr     = div10;

        if (cfg_wr) begin
            unique case (paddr[2])
                REG_ENABLE: enable_next = pwdata[0];
                REG_WINDOW: window_next = pwdata[WIN_W-1:0];
                default:    enable_next = enable_reg;
            endcase
        end

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    width_next = s_tdata[WIDTH_W-1:0];
                    now_next   = s_tdata[WIDTH_W+TIME_W-1:WIDTH_W];
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                done_next  = 1'b0;
                state_next = ST_OUT;
                if (enable_reg) begin
                    sum_next = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
                    if (elapsed >= {{(TIME_W-WIN_W){1'b0}}, window_reg}) begin
                        state_next = ST_RCHK;
                    end
                end
            end
            ST_RCHK: begin
                if (div10 == '0) begin
                    ratio_next = (sum_reg != '0) ? RATIO_MAX : '0;
                    state_next = ST_SQ;
                end else if (sum_reg >= {{(SUM_W-26){1'b0}}, lim}) begin
                    ratio_next = RATIO_MAX;
                    state_next = ST_SQ;
                end else begin
                    div_ctl    = '{start: 1'b1, steps: STEPS_RATIO};
                    div_rem    = {1'b0, sum_reg[25:7]};
                    div_dvd    = {sum_reg[6:0], {(DVD_W-7){1'b0}}};
                    div_dsr    = div10;
                    state_next = ST_RDIV;
                end
            end
            ST_RDIV: begin
                if (div_done) begin
                    ratio_next = div_quo[RATIO_W-1:0];
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                state_next = ST_CUBE;
            end
            ST_CUBE: begin
                r2_next    = prod_reg[R2_W+15:16];
                mul_a      = {{(MUL_A_W-R2_W){1'b0}}, prod_reg[R2_W+15:16]};
                state_next = ST_T3;
            end
            ST_T3: begin
                mul_a      = prod_reg[MUL_A_W+15:16];
                mul_b      = K_CUBE;
                state_next = ST_T2;
            end
            ST_T2: begin
                acc_next   = prod_s + K_OFFSET;
                mul_a      = {{(MUL_A_W-R2_W){1'b0}}, r2_reg};
                mul_b      = K_SQUARE;
                state_next = ST_T1;
            end
            ST_T1: begin
                acc_next   = acc_reg - prod_s;
                mul_b      = K_LINEAR;
                state_next = ST_TSUM;
            end
            ST_TSUM: begin
                acc_next   = acc_reg + prod_s;
                state_next = ST_CDIV;
            end
            ST_CDIV: begin
                if (m_val >= CONC_LIM) begin
                    conc_next  = CONC_MAX;
                    state_next = ST_SMS;
                end else begin
                    mul_a      = m_val;
                    mul_b      = RECIP_HUNDRED;
                    state_next = ST_CEST;
                end
            end
            ST_CEST: begin
                // estimate lies at most 12 below the true quotient
                est_next   = prod_reg[2*CONC_W-1:CONC_W];
                mul_a      = {{(MUL_A_W-CONC_W){1'b0}}, prod_reg[2*CONC_W-1:CONC_W]};
                mul_b      = K_HUNDRED;
                state_next = ST_CREM;
            end
            ST_CREM: begin
                mul_a      = c_rem;
                mul_b      = RECIP_HUNDRED_FINE;
                state_next = ST_CFIX;
            end
            ST_CFIX: begin
                conc_next  = est_reg + {{(CONC_W-5){1'b0}}, prod_reg[23:19]};
                state_next = ST_SMS;
            end
            ST_SMS: begin
                mul_a      = {4'b0, x_val};
                mul_b      = RECIP_TEN;
                state_next = ST_SEST;
            end
            ST_SEST: begin
                // estimate lies at most 32 below the true quotient
                est_next   = prod_reg[CONC_W+25:26];
                mul_a      = {{(MUL_A_W-CONC_W){1'b0}}, prod_reg[CONC_W+25:26]};
                mul_b      = K_TEN;
                state_next = ST_SREM;
            end
            ST_SREM: begin
                mul_a      = s_rem;
                mul_b      = RECIP_TEN_FINE;
                state_next = ST_SFIX;
            end
            ST_SFIX: begin
                last_next   = conc_reg;
                smooth_next = est_reg + {{(CONC_W-6){1'b0}}, prod_reg[16:11]};
                sum_next    = '0;
                start_next  = now_reg;
                done_next   = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {6'b0, smooth_reg, last_reg};
                    muser_next  = done_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            enable_reg <= ENABLE_RST;
            window_reg <= WINDOW_RST;
            sum_reg    <= '0;
            start_reg  <= '0;
            last_reg   <= '0;
            smooth_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            enable_reg <= enable_next;
            window_reg <= window_next;
            sum_reg    <= sum_next;
            start_reg  <= start_next;
            last_reg   <= last_next;
            smooth_reg <= smooth_next;
            mvalid_reg <= mvalid_next;
        end
        width_reg <= width_next;
        now_reg   <= now_next;
        ratio_reg <= ratio_next;
        r2_reg    <= r2_next;
        conc_reg  <= conc_next;
        est_reg   <= est_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        done_reg  <= done_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

endmodule

// ----- hdl/dpof_div.sv -----
`timescale 1ns / 1ps
// dpof_div: serial restoring divider, one quotient bit per cycle
// depends on dpof_pkg
module dpof_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dpof_pkg::div_ctl_t       ctl,
    input  logic [dpof_pkg::DSR_W-1:0] rem_init,
    input  logic [dpof_pkg::DVD_W-1:0] dvd_init,
    input  logic [dpof_pkg::DSR_W-1:0] dsr,
    output logic                     done,
    output logic [dpof_pkg::DVD_W-1:0] quo
);
    import dpof_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DSR_W-1:0]  rem_reg, rem_next;
    logic [DSR_W-1:0]  dsr_reg, dsr_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DSR_W:0]    trial;
    logic [DSR_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = !diff[DSR_W];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = ctl.steps;
            rem_next  = rem_init;
            dsr_next  = dsr;
            dvd_next  = dvd_init;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- verif/tb_dust_pulse_occupancy_filter_top.sv -----
`timescale 1ns / 1ps
// tb_dust_pulse_occupancy_filter_top: self-checking testbench for the dust pulse occupancy filter
// predicts every result in fixed point, drives random stream traffic and apb register writes
// depends on dpof_pkg and dust_pulse_occupancy_filter_top

module tb_dust_pulse_occupancy_filter_top;
    import dpof_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int QUIET_LEN   = 120;
    localparam int HOLD_LEN    = 800;

    typedef struct packed {
        logic              done;
        logic [CONC_W-1:0] latest;
        logic [CONC_W-1:0] filtered;
    } dust_reading_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [55:0]        s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [63:0]        m_tdata;
    logic               m_tuser;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // predictor state and register mirror
    logic               cfg_enable = ENABLE_RST;
    logic [WIN_W-1:0]   cfg_window = WINDOW_RST;
    logic [SUM_W-1:0]   acc_us = '0;
    logic [TIME_W-1:0]  win_start = '0;
    logic [CONC_W-1:0]  last_conc = '0;
    logic [CONC_W-1:0]  smoothed = '0;

    dust_reading_t      pending_readings[$];
    logic [TIME_W-1:0]  cur_ms = '0;
    int unsigned        tx_idle_pct = 0;
    int unsigned        rx_idle_pct = 0;
    int unsigned        rx_hold = 0;
    int unsigned        errors = 0;
    int unsigned        cycle_count = 0;

    dust_pulse_occupancy_filter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ratio in percent, unsigned Q7.16
    function automatic longint unsigned occupancy_q16(logic [SUM_W-1:0] acc,
                                                      logic [WIN_W-1:0] win);
        longint unsigned span;
        span = 64'(win) * 10;
        if (span == 0)
            return (acc != 0) ? 64'(RATIO_MAX) : 64'd0;
        if (64'(acc) >= span * 100)
            return 64'(RATIO_MAX);
        return (64'(acc) << 16) / span;
    endfunction

    // 1.1r^3 - 3.8r^2 + 520r + 0.62, result in Q21.8
    function automatic logic [CONC_W-1:0] concentration_q8(longint unsigned r);
        longint unsigned r2, r3, c;
        longint          n;
        r2 = (r * r) >> 16;
        r3 = (r2 * r) >> 16;
        n = longint'(110 * r3) - longint'(380 * r2) + longint'(52000 * r)
          + longint'(62 * 65536);
        if (n < 0)
            n = 0;
        c = ($unsigned(n) + 64'd12800) / 64'd25600;
        return (c > 64'(CONC_MAX)) ? CONC_MAX : CONC_W'(c);
    endfunction

    function automatic dust_reading_t advance_dust_state(logic [WIDTH_W-1:0] width,
                                                         logic [TIME_W-1:0] now);
        dust_reading_t     r;
        logic [TIME_W-1:0] elapsed;
        longint unsigned   total, conc, blend;
        r.done = 1'b0;
        if (cfg_enable) begin
            total = 64'(acc_us) + 64'(width);
            acc_us = (total > 64'(SUM_MAX)) ? SUM_MAX : SUM_W'(total);
            elapsed = now - win_start;
            if (elapsed >= TIME_W'(cfg_window)) begin
                conc = 64'(concentration_q8(occupancy_q16(acc_us, cfg_window)));
                last_conc = CONC_W'(conc);
                blend = (64'd9 * 64'(smoothed) + conc + 64'd5) / 64'd10;
                smoothed = (blend > 64'(CONC_MAX)) ? CONC_MAX : CONC_W'(blend);
                acc_us = '0;
                win_start = now;
                r.done = 1'b1;
            end
        end
        r.latest = last_conc;
        r.filtered = smoothed;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        if (errors < 40)
            $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        dust_reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("unexpected result transfer", m_tdata, 0);
            end else begin
                want = pending_readings.pop_front();
                if (m_tuser !== want.done)
                    report_mismatch("window_done", m_tuser, want.done);
                if (m_tdata[CONC_W-1:0] !== want.latest)
                    report_mismatch("latest_concentration", m_tdata[CONC_W-1:0], want.latest);
                if (m_tdata[2*CONC_W-1:CONC_W] !== want.filtered)
                    report_mismatch("filtered_dust", m_tdata[2*CONC_W-1:CONC_W], want.filtered);
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(negedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic offer_pulse(logic [WIDTH_W-1:0] width, logic [TIME_W-1:0] now);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, now, width};
        do @(posedge aclk); while (!s_tready);
        cur_ms = now;
        pending_readings.push_back(advance_dust_state(width, now));
    endtask

    task automatic quiesce();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge aclk);
        repeat (QUIET_LEN) @(posedge aclk);
    endtask

    task automatic check_register(logic idx);
        logic [APB_DW-1:0] want;
        want = (idx == REG_ENABLE) ? APB_DW'(cfg_enable) : APB_DW'(cfg_window);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want)
            report_mismatch("register read", prdata, want);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_register(logic idx, logic [APB_DW-1:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_ENABLE)
            cfg_enable = value[0];
        else
            cfg_window = value[WIN_W-1:0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        check_register(idx);
    endtask

    // mostly ordinary steps, some random jumps, some landing exactly on or just before the window edge
    function automatic logic [TIME_W-1:0] pick_now();
        int unsigned       k;
        logic [TIME_W-1:0] win32;
        k = $urandom_range(99);
        win32 = TIME_W'(cfg_window);
        if (k < 8)
            return $urandom;
        if (k < 18)
            return win_start + win32;
        if (k < 24)
            return win_start + win32 - 1;
        return cur_ms + $urandom_range(0, win32 / 3 + 1);
    endfunction

    // scaled so that window ratios spread across the whole percent range
    function automatic logic [WIDTH_W-1:0] pick_width();
        int unsigned k, lim;
        k = $urandom_range(99);
        lim = int'(cfg_window) * 350 + 1;
        if (lim > 32'hFFFFF)
            lim = 32'hFFFFF;
        if (k < 10)
            return '0;
        if (k < 20)
            return '1;
        if (k < 45)
            return WIDTH_W'($urandom);
        return WIDTH_W'($urandom_range(0, lim));
    endfunction

    task automatic test_power_on_defaults();
        check_register(REG_ENABLE);
        check_register(REG_WINDOW);
        offer_pulse(20'd0, 32'd0);
        offer_pulse(20'hFFFFF, 32'd4999);
        offer_pulse(20'd12345, 32'd5000);
    endtask

    task automatic test_window_extremes();
        quiesce();
        set_register(REG_WINDOW, 32'd1);
        offer_pulse(20'd0, 32'd5001);
        offer_pulse(20'd1000, 32'd5002);
        offer_pulse(20'd999, 32'd5003);
        offer_pulse(20'd0, 32'd5003);
        quiesce();
        set_register(REG_WINDOW, 32'd65535);
        offer_pulse(20'hFFFFF, 32'd5003 + 32'd65534);
        offer_pulse(20'hFFFFF, 32'd5003 + 32'd65535);
    endtask

    task automatic test_time_wrap();
        quiesce();
        set_register(REG_WINDOW, 32'd100);
        offer_pulse(20'd500, 32'hFFFF_FFC0);
        offer_pulse(20'd500, 32'h0000_0010);
        offer_pulse(20'd500, 32'h0000_0030);
        // time running backwards looks like a very long elapsed time
        offer_pulse(20'd7, 32'h0000_0020);
    endtask

    task automatic test_zero_window();
        quiesce();
        set_register(REG_WINDOW, 32'd0);
        offer_pulse(20'd0, 32'd40);
        offer_pulse(20'd5, 32'd40);
        offer_pulse(20'd0, 32'd41);
    endtask

    task automatic test_disabled(int count);
        quiesce();
        set_register(REG_ENABLE, 32'd0);
        offer_pulse(20'hFFFFF, 32'hFFFF_FFFF);
        offer_pulse(20'd0, 32'd0);
        repeat (count)
            offer_pulse(pick_width(), pick_now());
        quiesce();
        set_register(REG_ENABLE, 32'd1);
    endtask

    task automatic test_random_traffic(int count, logic [WIN_W-1:0] win);
        quiesce();
        set_register(REG_WINDOW, APB_DW'(win));
        set_register(REG_ENABLE, 32'd1);
        repeat (count)
            offer_pulse(pick_width(), pick_now());
    endtask

    task automatic test_stalled_receiver();
        quiesce();
        set_register(REG_WINDOW, APB_DW'($urandom_range(2, 64)));
        @(posedge aclk);
        rx_hold = HOLD_LEN;
        repeat (60)
            offer_pulse(pick_width(), pick_now());
    endtask

    initial begin
        repeat (RESET_LEN) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 29;
        rx_idle_pct = 45;
        test_power_on_defaults();
        test_window_extremes();
        test_time_wrap();
        test_zero_window();
        test_disabled(0);
        test_random_traffic(90, WINDOW_RST);
        test_random_traffic(90, WIN_W'($urandom_range(2, 64)));
        test_random_traffic(90, WIN_W'($urandom_range(100, 3000)));
        test_random_traffic(90, 16'hFFFF);

        tx_idle_pct = 45;
        rx_idle_pct = 29;
        test_random_traffic(90, 16'd1);
        test_random_traffic(90, WIN_W'($urandom_range(3000, 65534)));
        test_random_traffic(90, 16'd0);
        test_random_traffic(90, WIN_W'($urandom_range(2, 64)));

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(90, WIN_W'($urandom_range(100, 3000)));
        test_random_traffic(90, WIN_W'($urandom_range(2, 400)));
        test_disabled(20);
        test_random_traffic(90, WINDOW_RST);
        test_stalled_receiver();

        quiesce();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/dpof_pkg.sv
hdl/dpof_div.sv
hdl/dust_pulse_occupancy_filter_top.sv
verif/tb_dust_pulse_occupancy_filter_top.sv
